### design/bmm_pkg.sv
package bmm_pkg;

  localparam int MAX_DIM    = 8;
  localparam int DATA_WIDTH = 16;
  localparam int DEPTH      = MAX_DIM * MAX_DIM;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int IDX_W      = $clog2(MAX_DIM);
  localparam int DIM_W      = 4;
  localparam int CNT_W      = $clog2(2 * DEPTH + 1);
  localparam int LOAD_W     = $clog2(2 * DEPTH);
  localparam int MUL_W      = 2 * DATA_WIDTH;
  localparam int PROD_W     = 35;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT   = 2'd2;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctl_t;

  // zero counts as one, anything above the maximum as the maximum
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] d;
    d = v;
    if (v == '0) begin
      d = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      d = DIM_W'(MAX_DIM);
    end
    return d;
  endfunction

endpackage

### design/batched_matrix_multiply.sv
// Batched matrix multiply, one shared multiply-accumulate.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data. Index 0 sets
// row_count, 1 inner_count, 2 col_count; any such write restarts the batch.
// Other indexes are ignored. Write only while the block is idle.
// Input: element_valid/element_ready, one element_value per transfer: A in
// row-major order, then B in row-major order.
// Output: product_valid/product_ready with product_value, out_row, out_col and
// last_of_batch, row-major, last_of_batch set on the final element.
// After B's last element the block stops taking input and computes. Each
// product element issues its inner products to the MAC one after another,
// then passes through store read, multiply and accumulate before hand-off.
// The single multiply-accumulate unit serves every product element in turn.
// A held product stalls the next dot product until it is taken; the last
// product of a batch may wait while loading of the next batch goes on.
// Reset sets all three dimensions to 8 and empties the batch; stores keep
// whatever they held.
module batched_matrix_multiply (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [bmm_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [bmm_pkg::DIM_W-1:0]              cfg_data,
  input  logic                                   element_valid,
  output logic                                   element_ready,
  input  logic signed [bmm_pkg::DATA_WIDTH-1:0]  element_value,
  output logic                                   product_valid,
  input  logic                                   product_ready,
  output logic signed [bmm_pkg::PROD_W-1:0]      product_value,
  output logic [bmm_pkg::IDX_W-1:0]              out_row,
  output logic [bmm_pkg::IDX_W-1:0]              out_col,
  output logic                                   last_of_batch
);

  localparam int ADDR_FW = bmm_pkg::IDX_W + bmm_pkg::DIM_W;

  typedef enum logic [1:0] {LOAD, ISSUE, WAIT} state_t;

  state_t                          state;
  logic [bmm_pkg::DIM_W-1:0]       row_count, inner_count, col_count;
  logic [bmm_pkg::DIM_W-1:0]       rows, inner, cols;
  logic [bmm_pkg::LOAD_W-1:0]      load_count, lc;
  logic [bmm_pkg::CNT_W-1:0]       a_total, total, b_off;
  logic [bmm_pkg::IDX_W-1:0]       r, c, k;
  logic [ADDR_FW-1:0]              a_addr_full, b_addr_full;
  logic                            accept, cfg_hit, a_we, b_we, batch_done;
  logic                            k_last, r_last, c_last, issue_go;
  bmm_pkg::mac_ctl_t               issue_ctl, rd_ctl;
  logic signed [bmm_pkg::DATA_WIDTH-1:0] a_rdata, b_rdata;
  logic signed [bmm_pkg::PROD_W-1:0]     mac_acc;
  logic                            mac_done;

  assign rows  = bmm_pkg::eff_dim(row_count);
  assign inner = bmm_pkg::eff_dim(inner_count);
  assign cols  = bmm_pkg::eff_dim(col_count);

  assign a_total = bmm_pkg::CNT_W'(rows) * bmm_pkg::CNT_W'(inner);
  assign total   = a_total + bmm_pkg::CNT_W'(inner) * bmm_pkg::CNT_W'(cols);

  assign cfg_ready     = 1'b1;
  assign element_ready = (state == LOAD);
  assign accept        = element_valid && element_ready;
  assign cfg_hit       = cfg_valid && (cfg_index == bmm_pkg::REG_ROW_COUNT ||
                         cfg_index == bmm_pkg::REG_INNER_COUNT ||
                         cfg_index == bmm_pkg::REG_COL_COUNT);

  assign lc         = (bmm_pkg::CNT_W'(load_count) >= total) ? '0 : load_count;
  assign a_we       = accept && (bmm_pkg::CNT_W'(lc) < a_total);
  assign b_we       = accept && !(bmm_pkg::CNT_W'(lc) < a_total);
  assign b_off      = bmm_pkg::CNT_W'(lc) - a_total;
  assign batch_done = (bmm_pkg::CNT_W'(lc) + bmm_pkg::CNT_W'(1)) == total;

  assign a_addr_full = ADDR_FW'(r) * ADDR_FW'(inner) + ADDR_FW'(k);
  assign b_addr_full = ADDR_FW'(k) * ADDR_FW'(cols) + ADDR_FW'(c);

  assign k_last = bmm_pkg::DIM_W'(k) == inner - bmm_pkg::DIM_W'(1);
  assign r_last = bmm_pkg::DIM_W'(r) == rows - bmm_pkg::DIM_W'(1);
  assign c_last = bmm_pkg::DIM_W'(c) == cols - bmm_pkg::DIM_W'(1);

  // a new dot product starts only once the output register is free
  assign issue_go = (state == ISSUE) &&
                    ((k != '0) || !product_valid || product_ready);

  always_comb begin
    issue_ctl.valid = issue_go;
    issue_ctl.first = (k == '0);
    issue_ctl.last  = k_last;
  end

  bmm_ram #(
    .DEPTH (bmm_pkg::DEPTH),
    .WIDTH (bmm_pkg::DATA_WIDTH)
  ) u_a_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (lc[bmm_pkg::ADDR_W-1:0]),
    .wdata (element_value),
    .raddr (a_addr_full[bmm_pkg::ADDR_W-1:0]),
    .rdata (a_rdata)
  );

  bmm_ram #(
    .DEPTH (bmm_pkg::DEPTH),
    .WIDTH (bmm_pkg::DATA_WIDTH)
  ) u_b_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_off[bmm_pkg::ADDR_W-1:0]),
    .wdata (element_value),
    .raddr (b_addr_full[bmm_pkg::ADDR_W-1:0]),
    .rdata (b_rdata)
  );

  bmm_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctl  (rd_ctl),
    .a    (a_rdata),
    .b    (b_rdata),
    .acc  (mac_acc),
    .done (mac_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= LOAD;
      row_count     <= bmm_pkg::DIM_W'(bmm_pkg::MAX_DIM);
      inner_count   <= bmm_pkg::DIM_W'(bmm_pkg::MAX_DIM);
      col_count     <= bmm_pkg::DIM_W'(bmm_pkg::MAX_DIM);
      load_count    <= '0;
      r             <= '0;
      c             <= '0;
      k             <= '0;
      rd_ctl        <= '0;
      product_valid <= 1'b0;
    end else begin
      rd_ctl <= issue_ctl;
      if (product_valid && product_ready) begin
        product_valid <= 1'b0;
      end
      if (cfg_hit) begin
        load_count <= '0;
        case (cfg_index)
          bmm_pkg::REG_ROW_COUNT:   row_count   <= cfg_data;
          bmm_pkg::REG_INNER_COUNT: inner_count <= cfg_data;
          bmm_pkg::REG_COL_COUNT:   col_count   <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        LOAD: begin
          if (accept) begin
            if (batch_done) begin
              load_count <= '0;
              r          <= '0;
              c          <= '0;
              k          <= '0;
              state      <= ISSUE;
            end else begin
              load_count <= lc + bmm_pkg::LOAD_W'(1);
            end
          end
        end
        ISSUE: begin
          if (issue_go) begin
            if (k_last) begin
              k     <= '0;
              state <= WAIT;
            end else begin
              k <= k + bmm_pkg::IDX_W'(1);
            end
          end
        end
        WAIT: begin
          if (mac_done) begin
            product_valid <= 1'b1;
            product_value <= mac_acc;
            out_row       <= r;
            out_col       <= c;
            last_of_batch <= r_last && c_last;
            if (c_last) begin
              c <= '0;
              if (r_last) begin
                r     <= '0;
                state <= LOAD;
              end else begin
                r     <= r + bmm_pkg::IDX_W'(1);
                state <= ISSUE;
              end
            end else begin
              c     <= c + bmm_pkg::IDX_W'(1);
              state <= ISSUE;
            end
          end
        end
        default: state <= LOAD;
      endcase
    end
  end

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    mac_done |-> state == WAIT)
    else $error("accumulator finished outside the wait state");

  a_out_free_at_done: assert property (@(posedge clk) disable iff (rst)
    mac_done |-> !product_valid)
    else $error("dot product finished while output register still full");

  a_last_is_corner: assert property (@(posedge clk) disable iff (rst)
    (product_valid && last_of_batch) |->
      (bmm_pkg::DIM_W'(out_row) == rows - bmm_pkg::DIM_W'(1) &&
       bmm_pkg::DIM_W'(out_col) == cols - bmm_pkg::DIM_W'(1)))
    else $error("last flag on a product element that is not the final one");

  a_no_issue_while_load: assert property (@(posedge clk) disable iff (rst)
    rd_ctl.valid |-> $past(state) == ISSUE)
    else $error("store read issued outside the issue state");

endmodule

### design/bmm_ram.sv
module bmm_ram #(
  parameter int DEPTH  = 64,
  parameter int WIDTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/bmm_mac.sv
module bmm_mac (
  input  logic                                    clk,
  input  logic                                    rst,
  input  bmm_pkg::mac_ctl_t                       ctl,
  input  logic signed [bmm_pkg::DATA_WIDTH-1:0]   a,
  input  logic signed [bmm_pkg::DATA_WIDTH-1:0]   b,
  output logic signed [bmm_pkg::PROD_W-1:0]       acc,
  output logic                                    done
);

  logic signed [bmm_pkg::MUL_W-1:0] prod;
  bmm_pkg::mac_ctl_t                p_ctl;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_ctl <= '0;
      done  <= 1'b0;
    end else begin
      p_ctl <= ctl;
      done  <= p_ctl.valid && p_ctl.last;
    end
    prod <= a * b;
    if (p_ctl.valid) begin
      if (p_ctl.first) begin
        acc <= bmm_pkg::PROD_W'(prod);
      end else begin
        acc <= acc + bmm_pkg::PROD_W'(prod);
      end
    end
  end

endmodule

### tb/tb_batched_matrix_multiply.sv
module tb_batched_matrix_multiply;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_ITEMS  = 250;
  localparam int STEADY_ITEMS  = 80;
  localparam logic [bmm_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct {
    logic signed [bmm_pkg::PROD_W-1:0] value;
    logic [bmm_pkg::IDX_W-1:0]         row;
    logic [bmm_pkg::IDX_W-1:0]         col;
    logic                              last;
  } product_t;

  logic                                   clk = 1'b0;
  logic                                   rst = 1'b1;
  logic                                   cfg_valid = 1'b0;
  logic                                   cfg_ready;
  logic [bmm_pkg::CFG_IDX_W-1:0]          cfg_index = '0;
  logic [bmm_pkg::DIM_W-1:0]              cfg_data = '0;
  logic                                   element_valid = 1'b0;
  logic                                   element_ready;
  logic signed [bmm_pkg::DATA_WIDTH-1:0]  element_value = '0;
  logic                                   product_valid;
  logic                                   product_ready = 1'b0;
  logic signed [bmm_pkg::PROD_W-1:0]      product_value;
  logic [bmm_pkg::IDX_W-1:0]              out_row;
  logic [bmm_pkg::IDX_W-1:0]              out_col;
  logic                                   last_of_batch;

  batched_matrix_multiply i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .element_valid (element_valid),
    .element_ready (element_ready),
    .element_value (element_value),
    .product_valid (product_valid),
    .product_ready (product_ready),
    .product_value (product_value),
    .out_row       (out_row),
    .out_col       (out_col),
    .last_of_batch (last_of_batch)
  );

  always #2 clk = ~clk;

  logic signed [bmm_pkg::DATA_WIDTH-1:0] pending_elements[$];
  product_t                              expected_products[$];
  int                                    elements_queued = 0;
  int                                    elements_taken = 0;
  int                                    mismatch_count = 0;
  int                                    cycle_count = 0;
  bit                                    elem_fire = 1'b0;
  bit                                    cfg_fire = 1'b0;
  bit                                    steady = 1'b0;

  // predictor state
  logic [bmm_pkg::DIM_W-1:0]             dim_rows;
  logic [bmm_pkg::DIM_W-1:0]             dim_inner;
  logic [bmm_pkg::DIM_W-1:0]             dim_cols;
  int                                    fill_count;
  logic signed [bmm_pkg::DATA_WIDTH-1:0] a_mem[bmm_pkg::DEPTH];
  logic signed [bmm_pkg::DATA_WIDTH-1:0] b_mem[bmm_pkg::DEPTH];

  function automatic int clamp_dim(input logic [bmm_pkg::DIM_W-1:0] v);
    return (v == 0) ? 1 : ((v > bmm_pkg::MAX_DIM) ? bmm_pkg::MAX_DIM : int'(v));
  endfunction

  function automatic void apply_dim_write(input logic [bmm_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [bmm_pkg::DIM_W-1:0] val);
    bit known;
    known = 1'b1;
    case (idx)
      bmm_pkg::REG_ROW_COUNT: begin
        dim_rows = val;
      end
      bmm_pkg::REG_INNER_COUNT: begin
        dim_inner = val;
      end
      bmm_pkg::REG_COL_COUNT: begin
        dim_cols = val;
      end
      default: begin
        known = 1'b0;
      end
    endcase
    if (known) fill_count = 0;
  endfunction

  function automatic void load_and_multiply(
    input logic signed [bmm_pkg::DATA_WIDTH-1:0] v
  );
    int rows;
    int inner;
    int cols;
    int a_total;
    int total;
    logic signed [bmm_pkg::PROD_W-1:0] acc;
    product_t p;
    rows    = clamp_dim(dim_rows);
    inner   = clamp_dim(dim_inner);
    cols    = clamp_dim(dim_cols);
    a_total = rows * inner;
    total   = a_total + inner * cols;
    if (fill_count >= total) fill_count = 0;
    if (fill_count < a_total) begin
      a_mem[fill_count] = v;
    end else begin
      b_mem[fill_count - a_total] = v;
    end
    fill_count++;
    if (fill_count == total) begin
      fill_count = 0;
      for (int r = 0; r < rows; r++) begin
        for (int c = 0; c < cols; c++) begin
          acc = '0;
          for (int k = 0; k < inner; k++) begin
            acc = acc + a_mem[r * inner + k] * b_mem[k * cols + c];
          end
          p.value = acc;
          p.row   = bmm_pkg::IDX_W'(r);
          p.col   = bmm_pkg::IDX_W'(c);
          p.last  = (r == rows - 1) && (c == cols - 1);
          expected_products.insert(expected_products.size(), p);
        end
      end
    end
  endfunction

  function automatic logic [bmm_pkg::DIM_W-1:0] random_dim();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) return '0;
    if (roll < 16) return bmm_pkg::DIM_W'($urandom_range(9, 15));
    if (roll < 24) return bmm_pkg::DIM_W'(bmm_pkg::MAX_DIM);
    if (roll < 34) return bmm_pkg::DIM_W'($urandom_range(5, 7));
    return bmm_pkg::DIM_W'($urandom_range(1, 4));
  endfunction

  function automatic logic signed [bmm_pkg::DATA_WIDTH-1:0] random_element();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) return 16'sh8000;
    if (roll < 16) return 16'sh7fff;
    if (roll < 22) return '0;
    if (roll < 40) return bmm_pkg::DATA_WIDTH'($urandom_range(0, 511) - 256);
    return bmm_pkg::DATA_WIDTH'($urandom());
  endfunction

  task automatic queue_element(input logic signed [bmm_pkg::DATA_WIDTH-1:0] v);
    pending_elements.insert(pending_elements.size(), v);
    elements_queued++;
  endtask

  // call at a falling edge; returns at the falling edge after the transfer
  task automatic write_reg(input logic [bmm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bmm_pkg::DIM_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk); while (!cfg_fire);
  endtask

  task automatic end_writes();
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (elements_taken != elements_queued || expected_products.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // element driver
  always @(negedge clk) begin
    if (rst) begin
      element_valid <= 1'b0;
    end else if (element_valid && !elem_fire) begin
      element_valid <= 1'b1;
    end else if (pending_elements.size() != 0 &&
                 (steady || $urandom_range(0, 99) >= 25)) begin
      element_valid <= 1'b1;
      element_value <= pending_elements.pop_front();
    end else begin
      element_valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    product_ready <= steady || ($urandom_range(0, 99) >= 25);
  end

  // monitor and checker
  always @(posedge clk) begin
    product_t want;
    elem_fire = element_valid && element_ready;
    cfg_fire  = cfg_valid && cfg_ready;
    if (rst) begin
      dim_rows   = bmm_pkg::DIM_W'(bmm_pkg::MAX_DIM);
      dim_inner  = bmm_pkg::DIM_W'(bmm_pkg::MAX_DIM);
      dim_cols   = bmm_pkg::DIM_W'(bmm_pkg::MAX_DIM);
      fill_count = 0;
    end else begin
      if (cfg_fire) apply_dim_write(cfg_index, cfg_data);
      if (elem_fire) begin
        elements_taken++;
        load_and_multiply(element_value);
      end
      if (product_valid && product_ready) begin
        if (expected_products.size() == 0) begin
          $display("%0t: unexpected product: value %0d row %0d col %0d last %0b",
                   $time, product_value, out_row, out_col, last_of_batch);
          mismatch_count++;
        end else begin
          want = expected_products.pop_front();
          if (product_value !== want.value) begin
            $display("%0t: product_value expected %0d got %0d",
                     $time, want.value, product_value);
            mismatch_count++;
          end
          if (out_row !== want.row) begin
            $display("%0t: out_row expected %0d got %0d", $time, want.row, out_row);
            mismatch_count++;
          end
          if (out_col !== want.col) begin
            $display("%0t: out_col expected %0d got %0d", $time, want.col, out_col);
            mismatch_count++;
          end
          if (last_of_batch !== want.last) begin
            $display("%0t: last_of_batch expected %0b got %0b",
                     $time, want.last, last_of_batch);
            mismatch_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("batched_matrix_multiply test failed");
      $finish;
    end
  end

  initial begin
    logic [bmm_pkg::DIM_W-1:0] rv;
    logic [bmm_pkg::DIM_W-1:0] iv;
    logic [bmm_pkg::DIM_W-1:0] cv;
    int total;
    int batches;
    int cut;
    int random_sent;
    bit broken;

    random_sent = 0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // inner count left at reset; full-scale operands give the largest sum
    write_reg(bmm_pkg::REG_ROW_COUNT, 4'd1);
    write_reg(bmm_pkg::REG_COL_COUNT, 4'd1);
    end_writes();
    for (int i = 0; i < 2 * bmm_pkg::MAX_DIM; i++) queue_element(16'sh8000);
    wait_idle();

    // zero dimension counts as one
    write_reg(bmm_pkg::REG_INNER_COUNT, 4'd0);
    end_writes();
    queue_element(16'sh8000);
    queue_element(16'sh7fff);
    queue_element(16'sh7fff);
    queue_element(16'sh7fff);
    queue_element(16'sd1);
    queue_element(-16'sd1);
    wait_idle();

    // unused register index must not restart a batch in progress
    @(posedge clk);
    queue_element(-16'sd300);
    wait_idle();
    write_reg(REG_UNUSED, 4'hf);
    end_writes();
    queue_element(16'sd77);
    wait_idle();

    // dimension write during a partial batch restarts it
    write_reg(bmm_pkg::REG_ROW_COUNT, 4'd2);
    end_writes();
    queue_element(16'sd5);
    queue_element(-16'sd9);
    wait_idle();
    write_reg(bmm_pkg::REG_COL_COUNT, 4'd0);
    end_writes();
    queue_element(16'sh0100);
    queue_element(-16'sh0080);
    queue_element(16'sh7fff);
    wait_idle();

    while (random_sent < RANDOM_ITEMS) begin
      steady = (random_sent < STEADY_ITEMS);
      rv = random_dim();
      iv = random_dim();
      cv = random_dim();
      write_reg(bmm_pkg::REG_ROW_COUNT, rv);
      write_reg(bmm_pkg::REG_INNER_COUNT, iv);
      write_reg(bmm_pkg::REG_COL_COUNT, cv);
      if ($urandom_range(0, 4) == 0) write_reg(REG_UNUSED, bmm_pkg::DIM_W'($urandom()));
      end_writes();
      total   = clamp_dim(iv) * (clamp_dim(rv) + clamp_dim(cv));
      batches = $urandom_range(1, 3);
      broken  = 1'b0;
      for (int b = 0; b < batches && !broken && random_sent < RANDOM_ITEMS; b++) begin
        cut = total;
        if (total > 1 && $urandom_range(0, 9) == 0) begin
          cut    = $urandom_range(1, total - 1);
          broken = 1'b1;
        end
        if (cut > RANDOM_ITEMS - random_sent) begin
          cut    = RANDOM_ITEMS - random_sent;
          broken = 1'b1;
        end
        for (int i = 0; i < cut; i++) queue_element(random_element());
        random_sent += cut;
      end
      wait_idle();
    end

    steady = 1'b0;
    wait_idle();
    if (mismatch_count == 0) begin
      $display("batched_matrix_multiply test passed");
    end else begin
      $display("batched_matrix_multiply test failed");
    end
    $finish;
  end

endmodule
